[rtl/tfp_pkg.sv]
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types and constants for the telemetry frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam logic [7:0] CH_START = 8'h3C;  // '<'
  localparam logic [7:0] CH_END   = 8'h3E;  // '>'
  localparam logic [7:0] CH_SEP   = 8'h2C;  // ','
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_REQ   = 8'h32;  // '2'
  localparam logic [7:0] CH_DATA  = 8'h31;  // '1'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int FRAME_LEN = 16;
  localparam int POS_W     = $clog2(FRAME_LEN);

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_START = POS_W'(0);
  localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SEP0  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CHG0  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_CHG1  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SEP1  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_MIN0  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_MIN1  = POS_W'(7);
  localparam logic [POS_W-1:0] POS_MIN2  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_SEP2  = POS_W'(9);
  localparam logic [POS_W-1:0] POS_RPM0  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_RPM1  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_RPM2  = POS_W'(12);
  localparam logic [POS_W-1:0] POS_RPM3  = POS_W'(13);
  localparam logic [POS_W-1:0] POS_RPM4  = POS_W'(14);
  localparam logic [POS_W-1:0] POS_END   = POS_W'(15);

  localparam int TQ_DEPTH = 2;  // front-to-back token queue
  localparam int OQ_DEPTH = 2;  // result queue

  typedef enum logic [1:0] {
    EV_VALID = 2'd0,
    EV_TSREQ = 2'd1,
    EV_BAD   = 2'd2
  } event_kind_t;

  // one stored frame byte, classified by the front
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic             req_end;  // closes a "<2>" request
  } token_t;

  typedef struct packed {
    event_kind_t kind;
    logic [6:0]  charge_raw;
    logic [6:0]  charge_held;
    logic [9:0]  minutes_left;
    logic [16:0] engine_rpm;
  } result_t;

endpackage

[rtl/telemetry_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// telemetry_frame_parser_unit
// Parses ASCII telemetry frames <1,dd,ddd,ddddd> and "<2>" requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a received word (in_rx_byte) is taken
//   on a rising edge with push high and full low. One word per cycle is
//   sustained while full stays low. Result side is a queue read port: while
//   empty is low the oldest result sits on out_*; it is taken with pop high.
//   A result appears after the last word of a frame ('>' at position 15, or
//   the '>' of "<2>"): the front classifies that word in its accept cycle
//   and writes the token queue, then the back takes the token and writes the
//   result queue, which sets empty low.
//   Throughput is one word per cycle while full is low, set by the single-step
//   front tracker and the back accumulators, each one decimal digit per word.
//   If the receiver stalls, up to two results wait in the result queue;
//   the back then holds, the two-entry token queue fills, and full rises.
//   Reset (rst_n low, synchronous) drops any partial frame, empties both
//   queues and clears the held charge to zero.
// ----------------------------------------------------------------------------
module telemetry_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_event_kind,
  output logic [6:0]  out_charge_raw,
  output logic [6:0]  out_charge_held,
  output logic [9:0]  out_minutes_left,
  output logic [16:0] out_engine_rpm
);
  import tfp_pkg::*;

  logic    accept;
  logic    tok_push, tq_empty, tok_pop;
  token_t  tok_in, tok_head;
  result_t res_head;

  assign accept = push && !full;

  // front: start/space handling and byte position
  tfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .tok_push (tok_push),
    .tok      (tok_in)
  );

  // decouples the tracker from result back-pressure
  tfp_tok_queue u_tq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (tok_in),
    .full     (full),
    .pop      (tok_pop),
    .empty    (tq_empty),
    .head     (tok_head)
  );

  // back: layout check, decimal fields, result queue
  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (!tq_empty),
    .tok       (tok_head),
    .tok_pop   (tok_pop),
    .res_empty (empty),
    .res_pop   (pop),
    .res_head  (res_head)
  );

  assign out_event_kind   = res_head.kind;
  assign out_charge_raw   = res_head.charge_raw;
  assign out_charge_held  = res_head.charge_held;
  assign out_minutes_left = res_head.minutes_left;
  assign out_engine_rpm   = res_head.engine_rpm;

endmodule

[rtl/tfp_front.sv]
// ----------------------------------------------------------------------------
// tfp_front
// Frame tracking: start detection, space skipping, byte position.
// ----------------------------------------------------------------------------
module tfp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      rx_byte,
  output logic            tok_push,
  output tfp_pkg::token_t tok
);
  import tfp_pkg::*;

  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic             req_r, req_nxt;
  logic             is_start, stored;
  logic [POS_W-1:0] pos;

  assign is_start = (rx_byte == CH_START);
  assign pos      = is_start ? POS_START : count_r;
  assign stored   = is_start || (in_frame_r && (rx_byte != CH_SPACE));

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    req_nxt      = req_r;
    tok.pos      = pos;
    tok.data     = rx_byte;
    tok.req_end  = 1'b0;
    if (accept && stored) begin
      in_frame_nxt = 1'b1;
      count_nxt    = pos + POS_W'(1);
      if (pos == POS_TYPE) begin
        req_nxt = (rx_byte == CH_REQ);
      end
      if (pos == POS_SEP0 && req_r && rx_byte == CH_END) begin
        tok.req_end  = 1'b1;
        in_frame_nxt = 1'b0;
        count_nxt    = POS_START;
      end
      if (pos == POS_END) begin
        in_frame_nxt = 1'b0;
        count_nxt    = POS_START;
      end
    end
  end

  assign tok_push = accept && stored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= POS_START;
      req_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      req_r      <= req_nxt;
    end
  end

endmodule

[rtl/tfp_tok_queue.sv]
// ----------------------------------------------------------------------------
// tfp_tok_queue
// Short token queue between front and back; a push and a pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module tfp_tok_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tfp_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tfp_pkg::token_t head
);
  import tfp_pkg::*;

  localparam int PW = $clog2(TQ_DEPTH);
  localparam int CW = $clog2(TQ_DEPTH + 1);

  token_t         mem [TQ_DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(TQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(TQ_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(TQ_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

[rtl/tfp_back.sv]
// ----------------------------------------------------------------------------
// tfp_back
// Layout check, decimal accumulation, result build and result queue.
// ----------------------------------------------------------------------------
module tfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tok_valid,
  input  tfp_pkg::token_t  tok,
  output logic             tok_pop,
  output logic             res_empty,
  input  logic             res_pop,
  output tfp_pkg::result_t res_head
);
  import tfp_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  logic        ok_r, ok_nxt;
  logic [6:0]  chg_r, chg_nxt;
  logic [9:0]  min_r, min_nxt;
  logic [16:0] rpm_r, rpm_nxt;
  logic [6:0]  last_r, last_nxt;

  result_t       mem [OQ_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic          oq_full, step, emit, do_pop;
  result_t       res;
  logic          is_dig;
  logic [3:0]    dig;
  logic          good;

  assign oq_full   = (cnt_r == CW'(OQ_DEPTH));
  assign res_empty = (cnt_r == '0);
  assign res_head  = mem[rd_r];
  assign step      = tok_valid && !oq_full;
  assign tok_pop   = step;
  assign do_pop    = res_pop && !res_empty;

  assign is_dig = (tok.data >= CH_ZERO) && (tok.data <= CH_NINE);
  assign dig    = tok.data[3:0];
  assign good   = ok_r && (tok.data == CH_END);

  always_comb begin
    ok_nxt   = ok_r;
    chg_nxt  = chg_r;
    min_nxt  = min_r;
    rpm_nxt  = rpm_r;
    last_nxt = last_r;
    emit     = 1'b0;
    res.kind         = EV_BAD;
    res.charge_raw   = '0;
    res.charge_held  = last_r;
    res.minutes_left = '0;
    res.engine_rpm   = '0;
    if (step) begin
      unique case (tok.pos) inside
        POS_START: begin
          ok_nxt  = 1'b1;
          chg_nxt = '0;
          min_nxt = '0;
          rpm_nxt = '0;
        end
        POS_TYPE: ok_nxt = ok_r && (tok.data == CH_DATA);
        POS_SEP0, POS_SEP1, POS_SEP2: begin
          ok_nxt = ok_r && (tok.data == CH_SEP);
          if (tok.req_end) begin
            emit     = 1'b1;
            res.kind = EV_TSREQ;
          end
        end
        POS_CHG0, POS_CHG1: begin
          ok_nxt  = ok_r && is_dig;
          chg_nxt = 7'(chg_r * 7'd10 + 7'(dig));
        end
        POS_MIN0, POS_MIN1, POS_MIN2: begin
          ok_nxt  = ok_r && is_dig;
          min_nxt = 10'(min_r * 10'd10 + 10'(dig));
        end
        POS_RPM0, POS_RPM1, POS_RPM2, POS_RPM3, POS_RPM4: begin
          ok_nxt  = ok_r && is_dig;
          rpm_nxt = 17'(rpm_r * 17'd10 + 17'(dig));
        end
        POS_END: begin
          emit = 1'b1;
          if (good) begin
            res.kind         = EV_VALID;
            res.charge_raw   = chg_r;
            res.minutes_left = min_r;
            res.engine_rpm   = rpm_r;
            if (chg_r != '0) begin
              res.charge_held = chg_r;
              last_nxt        = chg_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    chg_r <= chg_nxt;
    min_r <= min_nxt;
    rpm_r <= rpm_nxt;
    if (emit) begin
      mem[wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      last_r <= last_nxt;
      if (emit) begin
        wr_r <= (wr_r == PW'(OQ_DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(OQ_DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(emit) - CW'(do_pop);
    end
  end

  // results only at the frame end or at a request close
  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (tok.pos == POS_END) || tok.req_end)
    else $error("result emitted mid-frame");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(OQ_DEPTH))
    else $error("result queue overflow");

  a_held_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.kind == EV_VALID && res.charge_raw != '0)
      |=> last_r == $past(res.charge_raw))
    else $error("held charge not updated");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !oq_full)
    else $error("result written into full queue");

endmodule
